/* hw/rtl/assert_macros.svh */
// assertion macros for the display formatter rtl
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LNF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define LNF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LNF_ASSERT(lbl, clk, rst_n, prop)
`define LNF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/lnf_pkg.sv */
// constants and codes of the lcd number format writer
// no dependencies; imported by every rtl module of the block
package lnf_pkg;
	localparam int DEF_MAX_DIGITS = 16;
	localparam int DEF_VALUE_BITS = 16;

	localparam int KIND_W   = 3;
	localparam int LINE_W   = 2;
	localparam int COLUMN_W = 6;
	localparam int VAL_IN_W = 16;
	localparam int COUNT_W  = 5;

	localparam logic [KIND_W-1:0] KIND_CHAR = 3'd0;
	localparam logic [KIND_W-1:0] KIND_UDEC = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SDEC = 3'd2;
	localparam logic [KIND_W-1:0] KIND_HEX  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_BIN  = 3'd4;

	localparam logic [LINE_W-1:0] LINE_ONE = 2'd1;
	localparam logic [LINE_W-1:0] LINE_TWO = 2'd2;

	localparam logic [7:0] CMD_CURSOR   = 8'h80;
	localparam logic [7:0] LINE2_OFFSET = 8'h40;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_A         = 8'h41;
	localparam logic [7:0] CH_PLUS      = 8'h2B;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [3:0] DIGIT_TEN    = 4'd10;
endpackage

/* hw/rtl/lcd_number_format_writer.sv */
// top level of the lcd number format writer: request capture, sequencer, output word
// depends on lnf_pkg, lnf_bcd_conv, lnf_digit_sel and assert_macros.svh
//
// channel  dir  handshake              payload
// s        in   s_tvalid / s_tready    s_tuser: kind; s_tdata: line, column, value, digit_count
// m        out  m_tvalid / m_tready    m_tuser: is_data; m_tdata: bus_byte; m_tlast: last
//
// one request is taken when idle, then one bus word leaves per cycle while m_tready holds,
// except that decimal digits wait for the bcd conversion that starts at accept
// s_tready is low from accept until the final word sits in the output register
// reset clears the sequencer and the output valid; a stalled m side holds the word
`include "assert_macros.svh"
module lcd_number_format_writer import lnf_pkg::*; #(
	parameter int MAX_DIGITS = DEF_MAX_DIGITS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // line[1:0], column[7:2], value[23:8], digit_count[28:24]
	input  logic [2:0]  s_tuser,  // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // bus_byte[7:0]
	output logic [0:0]  m_tuser,  // is_data[0]
	output logic        m_tlast
);
	localparam int BCD_DIGITS = VALUE_BITS * 30103 / 100000 + 1;
	localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMD  = 2'd1;
	localparam logic [1:0] ST_PRE  = 2'd2;
	localparam logic [1:0] ST_DIG  = 2'd3;

	logic [KIND_W-1:0]   in_kind;
	logic [LINE_W-1:0]   in_line;
	logic [COLUMN_W-1:0] in_column;
	logic [VAL_IN_W-1:0] in_value;
	logic [COUNT_W-1:0]  in_count;
	logic [VALUE_BITS-1:0] in_ext;
	logic [VALUE_BITS-1:0] in_mag;
	logic                in_neg;
	logic                in_cmd;
	logic                in_pre;
	logic                in_dig;
	logic                in_dec;
	logic [COUNT_W:0]    in_sat;
	logic [COUNT_W:0]    in_last_idx;
	logic                accept;

	logic [1:0]            state_q, state_d;
	logic [KIND_W-1:0]     kind_q;
	logic [7:0]            cursor_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic                  neg_q;
	logic                  pre_q;
	logic                  dig_q;
	logic [IDX_W-1:0]      idx_q, idx_d;

	logic                  m_tvalid_q;
	logic [7:0]            byte_q;
	logic                  data_q;
	logic                  last_q;

	logic                  slot;
	logic                  emit;
	logic [7:0]            emit_byte;
	logic                  emit_data;
	logic                  emit_last;

	logic                    conv_busy;
	logic [4*BCD_DIGITS-1:0] conv_bcd;
	logic [7:0]              digit_ch;
	logic                    dec_wait;

	assign in_kind   = s_tuser;
	assign in_line   = s_tdata[1:0];
	assign in_column = s_tdata[7:2];
	assign in_value  = s_tdata[23:8];
	assign in_count  = s_tdata[28:24];

	assign in_ext = VALUE_BITS'(in_value);
	assign in_neg = (in_kind == KIND_SDEC) && in_ext[VALUE_BITS-1];
	assign in_mag = in_neg ? (~in_ext + 1'b1) : in_ext;
	assign in_dec = (in_kind == KIND_UDEC) || (in_kind == KIND_SDEC);
	assign in_cmd = (in_line == LINE_ONE) || (in_line == LINE_TWO);
	assign in_pre = (in_kind == KIND_CHAR) || (in_kind == KIND_SDEC);
	assign in_dig = (in_dec || (in_kind == KIND_HEX) || (in_kind == KIND_BIN))
		&& (in_count != '0);
	assign in_sat = ({1'b0, in_count} > (COUNT_W + 1)'(MAX_DIGITS))
		? (COUNT_W + 1)'(MAX_DIGITS) : {1'b0, in_count};
	assign in_last_idx = in_sat - 1'b1;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign slot     = !m_tvalid_q || m_tready;
	assign dec_wait = ((kind_q == KIND_UDEC) || (kind_q == KIND_SDEC)) && conv_busy;

	lnf_bcd_conv #(
		.VALUE_BITS (VALUE_BITS),
		.BCD_DIGITS (BCD_DIGITS)
	) u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && in_dec),
		.value  (in_mag),
		.busy   (conv_busy),
		.bcd    (conv_bcd)
	);

	lnf_digit_sel #(
		.VALUE_BITS (VALUE_BITS),
		.BCD_DIGITS (BCD_DIGITS),
		.IDX_W      (IDX_W)
	) u_digit (
		.kind (kind_q),
		.idx  (idx_q),
		.mag  (mag_q),
		.bcd  (conv_bcd),
		.ch   (digit_ch)
	);

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		emit      = 1'b0;
		emit_byte = 8'h00;
		emit_data = 1'b0;
		emit_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (in_cmd) begin
						state_d = ST_CMD;
					end else if (in_pre) begin
						state_d = ST_PRE;
					end else if (in_dig) begin
						state_d = ST_DIG;
					end
				end
			end
			ST_CMD: begin
				if (slot) begin
					emit      = 1'b1;
					emit_byte = cursor_q;
					emit_last = !pre_q && !dig_q;
					if (pre_q) begin
						state_d = ST_PRE;
					end else if (dig_q) begin
						state_d = ST_DIG;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_PRE: begin
				if (slot) begin
					emit      = 1'b1;
					emit_data = 1'b1;
					emit_last = !dig_q;
					if (kind_q == KIND_CHAR) begin
						emit_byte = mag_q[7:0];
					end else if (neg_q) begin
						emit_byte = CH_MINUS;
					end else begin
						emit_byte = CH_PLUS;
					end
					state_d = dig_q ? ST_DIG : ST_IDLE;
				end
			end
			ST_DIG: begin
				if (slot && !dec_wait) begin
					emit      = 1'b1;
					emit_data = 1'b1;
					emit_byte = digit_ch;
					emit_last = (idx_q == '0);
					if (idx_q == '0) begin
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q - 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// cursor address wraps modulo 256 for column zero
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= in_kind;
			mag_q    <= (in_kind == KIND_CHAR) ? in_ext : in_mag;
			neg_q    <= in_neg;
			pre_q    <= in_pre;
			dig_q    <= in_dig;
			idx_q    <= IDX_W'(in_last_idx);
			cursor_q <= CMD_CURSOR | (({2'b00, in_column} - 8'd1)
				+ ((in_line == LINE_TWO) ? LINE2_OFFSET : 8'h00));
		end else begin
			idx_q <= idx_d;
		end
		if (emit) begin
			byte_q <= emit_byte;
			data_q <= emit_data;
			last_q <= emit_last;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = byte_q;
	assign m_tuser[0] = data_q;
	assign m_tlast    = last_q;

	`LNF_ASSERT(a_no_overwrite, clk, arst_n, emit |-> slot)
	`LNF_ASSERT_NEXT(a_last_frees_input, clk, arst_n, emit && emit_last, s_tready)
	`LNF_ASSERT(a_dig_numeric, clk, arst_n, (state_q == ST_DIG) |-> ((kind_q == KIND_UDEC)
		|| (kind_q == KIND_SDEC) || (kind_q == KIND_HEX) || (kind_q == KIND_BIN)))
	`LNF_ASSERT(a_dec_after_conv, clk, arst_n, (emit && (state_q == ST_DIG)) |-> !dec_wait)
endmodule

/* hw/rtl/lnf_bcd_conv.sv */
// shift-add-3 binary to bcd converter, one bit per cycle
// depends on lnf_pkg
module lnf_bcd_conv import lnf_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	parameter int BCD_DIGITS = VALUE_BITS * 30103 / 100000 + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [VALUE_BITS-1:0]   value,
	output logic                    busy,
	output logic [4*BCD_DIGITS-1:0] bcd
);
	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic [CNT_W-1:0]        cnt_q;
	logic [VALUE_BITS-1:0]   bin_q;
	logic [4*BCD_DIGITS-1:0] bcd_q;
	logic [4*BCD_DIGITS-1:0] adj;

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] > 4'd4) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(VALUE_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bcd_q <= {adj[4*BCD_DIGITS-2:0], bin_q[VALUE_BITS-1]};
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	assign busy = (cnt_q != '0);
	assign bcd  = bcd_q;
endmodule

/* hw/rtl/lnf_digit_sel.sv */
// picks one digit of the value by position and turns it into ascii
// depends on lnf_pkg
module lnf_digit_sel import lnf_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	parameter int BCD_DIGITS = VALUE_BITS * 30103 / 100000 + 1,
	parameter int IDX_W      = 4
) (
	input  logic [KIND_W-1:0]       kind,
	input  logic [IDX_W-1:0]        idx,
	input  logic [VALUE_BITS-1:0]   mag,
	input  logic [4*BCD_DIGITS-1:0] bcd,
	output logic [7:0]              ch
);
	logic [VALUE_BITS-1:0]   hex_sh;
	logic [VALUE_BITS-1:0]   bin_sh;
	logic [4*BCD_DIGITS-1:0] dec_sh;
	logic [3:0]              digit;

	// positions past the value width shift out to zero
	assign hex_sh = mag >> {idx, 2'b00};
	assign bin_sh = mag >> idx;
	assign dec_sh = bcd >> {idx, 2'b00};

	always_comb begin
		case (kind)
			KIND_UDEC, KIND_SDEC: digit = dec_sh[3:0];
			KIND_HEX:             digit = hex_sh[3:0];
			KIND_BIN:             digit = {3'b000, bin_sh[0]};
			default:              digit = 4'd0;
		endcase
		if (digit < DIGIT_TEN) begin
			ch = CH_ZERO + {4'b0000, digit};
		end else begin
			ch = CH_A + {4'b0000, digit - DIGIT_TEN};
		end
	end
endmodule

/* tb/tb_top.sv */
// self-checking testbench for lcd_number_format_writer: display requests in, lcd bus words out
// depends on lnf_pkg and the rtl of the block; predicts every word and compares it in order
// driver and monitor are clocked always blocks, with random gaps on both sides
module tb_top;
	import lnf_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 64;
	localparam int N_RANDOM    = 430;
	localparam int REPORT_MAX  = 10;

	localparam logic [KIND_W-1:0] KIND_RSVD5 = 3'd5;
	localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;
	localparam logic [LINE_W-1:0] LINE_NONE  = 2'd0;
	localparam logic [LINE_W-1:0] LINE_THREE = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [LINE_W-1:0]   line;
		logic [COLUMN_W-1:0] column;
		logic [VAL_IN_W-1:0] value;
		logic [COUNT_W-1:0]  digit_count;
	} disp_req_t;

	typedef struct packed {
		logic       is_data;
		logic [7:0] bus_byte;
		logic       last;
	} lcd_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;

	disp_req_t  pending_reqs[$];
	lcd_write_t exp_writes[$];
	disp_req_t  shown_req;
	int         gap_left = 0;
	int         stall_left = 0;
	int         n_accepted = 0;
	int         n_words = 0;
	int         n_errors = 0;
	int         n_cycles = 0;

	lcd_number_format_writer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] pack_req(input disp_req_t r);
		return {3'b000, r.digit_count, r.value, r.column, r.line};
	endfunction

	// no waiting during every third stretch of the given span
	function automatic int draw_wait(input int seq, input int span);
		if ((seq / span) % 3 == 2)
			return 0;
		return $urandom_range(0, 15);
	endfunction

	// expected bus words of one request, appended to exp_writes
	function automatic void format_request(input disp_req_t r);
		lcd_write_t  words[$];
		logic [7:0]  addr;
		logic [15:0] mag;
		logic [3:0]  digs[DEF_MAX_DIGITS];
		int unsigned base;
		int unsigned v;
		int          n_dig;
		base = 0;
		mag = r.value;
		if (r.line == LINE_ONE || r.line == LINE_TWO) begin
			addr = {2'b00, r.column} - 8'd1;
			if (r.line == LINE_TWO)
				addr = addr + LINE2_OFFSET;
			words.push_back('{1'b0, CMD_CURSOR | addr, 1'b0});
		end
		n_dig = (r.digit_count > DEF_MAX_DIGITS) ? DEF_MAX_DIGITS : int'(r.digit_count);
		case (r.kind)
			KIND_CHAR: begin
				words.push_back('{1'b1, r.value[7:0], 1'b0});
			end
			KIND_UDEC: base = 10;
			KIND_SDEC: begin
				base = 10;
				if (r.value[15]) begin
					words.push_back('{1'b1, CH_MINUS, 1'b0});
					mag = ~r.value + 16'd1;
				end else begin
					words.push_back('{1'b1, CH_PLUS, 1'b0});
				end
			end
			KIND_HEX: base = 16;
			KIND_BIN: base = 2;
			default: base = 0;
		endcase
		if (base != 0) begin
			v = {16'h0000, mag};
			for (int i = 0; i < n_dig; i++) begin
				digs[i] = 4'(v % base);
				v = v / base;
			end
			for (int i = n_dig; i > 0; i--) begin
				if (digs[i-1] < DIGIT_TEN)
					words.push_back('{1'b1, CH_ZERO + digs[i-1], 1'b0});
				else
					words.push_back('{1'b1, CH_A + digs[i-1] - DIGIT_TEN, 1'b0});
			end
		end
		if (words.size() != 0)
			words[words.size()-1].last = 1'b1;
		foreach (words[k])
			exp_writes.push_back(words[k]);
	endfunction

	function automatic disp_req_t make_random_req();
		disp_req_t r;
		int        sel;
		if ($urandom_range(0, 9) < 8) begin
			r.kind = KIND_W'($urandom_range(0, 4));
			r.line = ($urandom_range(0, 9) == 0) ? LINE_W'($urandom_range(0, 3))
				: LINE_W'($urandom_range(1, 2));
			r.column = COLUMN_W'($urandom_range(1, 40));
			r.digit_count = COUNT_W'($urandom_range(1, 16));
		end else begin
			r.kind = KIND_W'($urandom);
			r.line = LINE_W'($urandom);
			r.column = COLUMN_W'($urandom);
			r.digit_count = COUNT_W'($urandom);
		end
		sel = $urandom_range(0, 9);
		case (sel)
			0: r.value = 16'h0000;
			1: r.value = 16'hFFFF;
			2: r.value = 16'h8000;
			3: r.value = VAL_IN_W'($urandom_range(0, 99));
			default: r.value = VAL_IN_W'($urandom);
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left <= 0;
		end else if (s_tvalid && s_tready) begin
			format_request(shown_req);
			n_accepted++;
			g = draw_wait(n_accepted, 40);
			if (g == 0 && pending_reqs.size() != 0) begin
				shown_req = pending_reqs.pop_front();
				s_tdata <= pack_req(shown_req);
				s_tuser <= shown_req.kind;
			end else begin
				s_tvalid <= 1'b0;
				gap_left <= g;
			end
		end else if (!s_tvalid) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() != 0) begin
				shown_req = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= pack_req(shown_req);
				s_tuser <= shown_req.kind;
			end
		end
	end

	// word monitor and checker
	always @(posedge clk or negedge arst_n) begin
		lcd_write_t got;
		lcd_write_t want;
		int         st;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else if (m_tvalid && m_tready) begin
			got = '{m_tuser[0], m_tdata, m_tlast};
			n_words++;
			if (exp_writes.size() == 0) begin
				n_errors++;
				if (n_errors <= REPORT_MAX)
					$display("word %0d with nothing expected: is_data=%0b byte=%02h last=%0b",
						n_words, got.is_data, got.bus_byte, got.last);
			end else begin
				want = exp_writes.pop_front();
				if (got != want) begin
					n_errors++;
					if (n_errors <= REPORT_MAX)
						$display({"word %0d mismatch: expected is_data=%0b byte=%02h ",
							"last=%0b, got is_data=%0b byte=%02h last=%0b"},
							n_words, want.is_data, want.bus_byte, want.last,
							got.is_data, got.bus_byte, got.last);
				end
			end
			st = draw_wait(n_words, 60);
			if (st != 0) begin
				m_tready <= 1'b0;
				stall_left <= st;
			end
		end else if (!m_tready) begin
			if (stall_left != 0)
				stall_left <= stall_left - 1;
			else
				m_tready <= 1'b1;
		end
	end

	initial begin
		// directed: field extremes, every kind, corner cases
		pending_reqs.push_back('{KIND_CHAR, LINE_ONE, 6'd1, 16'h0000, 5'd1});
		pending_reqs.push_back('{KIND_CHAR, LINE_TWO, 6'd40, 16'hAB41, 5'd31});
		pending_reqs.push_back('{KIND_CHAR, LINE_NONE, 6'd5, 16'h00FF, 5'd3});
		pending_reqs.push_back('{KIND_UDEC, LINE_THREE, 6'd63, 16'd12345, 5'd5});
		pending_reqs.push_back('{KIND_UDEC, LINE_ONE, 6'd0, 16'hFFFF, 5'd5});
		pending_reqs.push_back('{KIND_UDEC, LINE_TWO, 6'd0, 16'hFFFF, 5'd16});
		pending_reqs.push_back('{KIND_UDEC, LINE_ONE, 6'd63, 16'd7, 5'd0});
		pending_reqs.push_back('{KIND_UDEC, LINE_TWO, 6'd20, 16'd65000, 5'd31});
		pending_reqs.push_back('{KIND_UDEC, LINE_ONE, 6'd16, 16'd99, 5'd17});
		pending_reqs.push_back('{KIND_SDEC, LINE_ONE, 6'd1, 16'h8000, 5'd5});
		pending_reqs.push_back('{KIND_SDEC, LINE_TWO, 6'd2, 16'h7FFF, 5'd5});
		pending_reqs.push_back('{KIND_SDEC, LINE_ONE, 6'd3, 16'hFFFF, 5'd16});
		pending_reqs.push_back('{KIND_SDEC, LINE_TWO, 6'd4, 16'h0000, 5'd0});
		pending_reqs.push_back('{KIND_SDEC, LINE_NONE, 6'd4, 16'h8000, 5'd0});
		pending_reqs.push_back('{KIND_HEX, LINE_ONE, 6'd10, 16'hABCD, 5'd4});
		pending_reqs.push_back('{KIND_HEX, LINE_TWO, 6'd11, 16'hF00F, 5'd16});
		pending_reqs.push_back('{KIND_HEX, LINE_ONE, 6'd12, 16'h0000, 5'd2});
		pending_reqs.push_back('{KIND_BIN, LINE_ONE, 6'd13, 16'hA5A5, 5'd16});
		pending_reqs.push_back('{KIND_BIN, LINE_TWO, 6'd14, 16'h0001, 5'd1});
		pending_reqs.push_back('{KIND_BIN, LINE_THREE, 6'd15, 16'hFFFF, 5'd31});
		pending_reqs.push_back('{KIND_RSVD5, LINE_NONE, 6'd1, 16'h1234, 5'd4});
		pending_reqs.push_back('{KIND_RSVD6, LINE_ONE, 6'd2, 16'h1234, 5'd4});
		pending_reqs.push_back('{KIND_RSVD7, LINE_TWO, 6'd3, 16'hFFFF, 5'd31});
		pending_reqs.push_back('{KIND_RSVD7, LINE_THREE, 6'd42, 16'h5555, 5'd10});
		for (int i = 0; i < N_RANDOM; i++)
			pending_reqs.push_back(make_random_req());

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_reqs.size() != 0 || s_tvalid)
			@(posedge clk);
		while (exp_writes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (exp_writes.size() != 0) begin
			n_errors++;
			$display("%0d expected words never arrived", exp_writes.size());
		end

		$display("ran %0d display requests of all kinds and lines, %0d bus words checked",
			n_accepted, n_words);
		if (n_errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d failures", n_errors);
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/lnf_pkg.sv
hw/rtl/lnf_bcd_conv.sv
hw/rtl/lnf_digit_sel.sv
hw/rtl/lcd_number_format_writer.sv
tb/tb_top.sv
